### sv/cse_pkg.sv
// package for the semaphore table engine
// sizes, opcode and status codes, control and status structs; no dependencies
`default_nettype none

package cse_pkg;

    localparam int SEM_COUNT  = 32;
    localparam int SLOT_COUNT = 32;
    localparam int PID_BITS   = 8;

    localparam int SEM_IW  = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
    localparam int SLOT_IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W   = 17;

    localparam logic signed [CNT_W-1:0] CNT_MAX = 17'sh0FFFF;
    localparam logic signed [CNT_W-1:0] CNT_MIN = 17'sh10000;

    localparam logic [1:0] OP_INIT   = 2'd0;
    localparam logic [1:0] OP_WAIT   = 2'd1;
    localparam logic [1:0] OP_SIGNAL = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_SEM = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
    } t_ctl;

    typedef struct packed {
        logic op_valid;
    } t_sts;

endpackage

`default_nettype wire

### sv/cse_ctrl.sv
// controller state machine of the semaphore table engine
// sequences capture, lookup, commit and result transaction; uses cse_pkg
`default_nettype none

module cse_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  wire logic          i_stall,
    input  wire cse_pkg::t_sts i_sts,
    output cse_pkg::t_ctl      o_ctl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: n_state = S_EXEC;
            S_EXEC: n_state = S_OUT;
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_ctl.capture = (r_state == S_IDLE) && i_valid;
    assign o_ctl.lookup  = (r_state == S_LOOK);
    assign o_ctl.commit  = (r_state == S_EXEC);

    a_commit_follows_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.lookup |=> o_ctl.commit)
        else $error("commit did not follow lookup");

    a_result_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.commit |=> o_valid)
        else $error("no result after commit");

    a_no_capture_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid || o_ctl.lookup || (o_ctl.commit && i_sts.op_valid)) |-> !o_ctl.capture)
        else $error("capture while a transaction is in flight");

endmodule

`default_nettype wire

### sv/cse_dp.sv
// datapath of the semaphore table engine: semaphore table, waiter slots, result register
// driven by cse_ctrl commands; uses cse_pkg
`default_nettype none

module cse_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire cse_pkg::t_ctl i_ctl,
    output cse_pkg::t_sts      o_sts,
    input  wire logic [1:0]    i_opcode,
    input  wire logic [7:0]    i_process_id,
    input  wire logic [4:0]    i_semaphore_id,
    input  wire logic [14:0]   i_initial_value,
    output logic [1:0]         o_status,
    output logic [4:0]         o_allocated_id,
    output logic               o_caller_blocked,
    output logic               o_wake_valid,
    output logic [7:0]         o_wake_process
);

    localparam int SEMS  = cse_pkg::SEM_COUNT;
    localparam int SLOTS = cse_pkg::SLOT_COUNT;
    localparam int SIW   = cse_pkg::SEM_IW;
    localparam int LIW   = cse_pkg::SLOT_IW;
    localparam int PW    = cse_pkg::PID_BITS;
    localparam int CW    = cse_pkg::CNT_W;

    // request registers
    logic [1:0]  r_op;
    logic [PW-1:0] r_pid;
    logic [4:0]  r_sid;
    logic [14:0] r_init;

    // semaphore table
    logic [SEMS-1:0]               r_in_use;
    logic signed [CW-1:0]          r_count [SEMS];
    logic [SEMS-1:0]               r_qne;
    logic [LIW-1:0]                r_head  [SEMS];
    logic [LIW-1:0]                r_tail  [SEMS];

    // waiter slots
    logic [SLOTS-1:0]              r_busy;
    logic [SLOTS-1:0]              r_next_ok;
    logic [LIW-1:0]                r_next  [SLOTS];
    logic [PW-1:0]                 r_owner [SLOTS];

    // lookup stage
    logic                 r_l_sid_ok;
    logic signed [CW-1:0] r_l_count;
    logic                 r_l_qne;
    logic [LIW-1:0]       r_l_head;
    logic [LIW-1:0]       r_l_tail;
    logic [PW-1:0]        r_l_owner_h;
    logic [LIW-1:0]       r_l_next_h;
    logic                 r_l_next_ok_h;
    logic                 r_l_sem_found;
    logic [SIW-1:0]       r_l_sem_idx;
    logic                 r_l_slot_found;
    logic [LIW-1:0]       r_l_slot_idx;

    // result register
    logic [1:0]    r_o_status;
    logic [4:0]    r_o_id;
    logic          r_o_blocked;
    logic          r_o_wake;
    logic [PW-1:0] r_o_who;

    logic [SIW-1:0]       sidx;
    logic                 sid_ok;
    logic                 sem_found;
    logic [SIW-1:0]       sem_idx;
    logic                 slot_found;
    logic [LIW-1:0]       slot_idx;
    logic signed [CW-1:0] c_dec;
    logic signed [CW-1:0] c_inc;
    logic                 op_ok;

    assign sidx   = SIW'(r_sid);
    assign sid_ok = (32'(r_sid) < SEMS);

    always_comb begin
        sem_found = 1'b0;
        sem_idx   = '0;
        for (int i = SEMS - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                sem_found = 1'b1;
                sem_idx   = SIW'(i);
            end
        end
    end

    always_comb begin
        slot_found = 1'b0;
        slot_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                slot_found = 1'b1;
                slot_idx   = LIW'(i);
            end
        end
    end

    assign c_dec = (r_l_count != cse_pkg::CNT_MIN) ? r_l_count - 17'sd1 : r_l_count;
    assign c_inc = (r_l_count != cse_pkg::CNT_MAX) ? r_l_count + 17'sd1 : r_l_count;
    assign op_ok = r_l_sid_ok && ((r_op == cse_pkg::OP_WAIT) || (r_op == cse_pkg::OP_SIGNAL));

    assign o_sts.op_valid = (r_op == cse_pkg::OP_INIT) || op_ok;

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_op   <= i_opcode;
            r_pid  <= PW'(i_process_id);
            r_sid  <= i_semaphore_id;
            r_init <= i_initial_value;
        end
        if (i_ctl.lookup) begin
            r_l_sid_ok     <= sid_ok;
            r_l_count      <= r_count[sidx];
            r_l_qne        <= r_qne[sidx];
            r_l_head       <= r_head[sidx];
            r_l_tail       <= r_tail[sidx];
            r_l_owner_h    <= r_owner[r_head[sidx]];
            r_l_next_h     <= r_next[r_head[sidx]];
            r_l_next_ok_h  <= r_next_ok[r_head[sidx]];
            r_l_sem_found  <= sem_found;
            r_l_sem_idx    <= sem_idx;
            r_l_slot_found <= slot_found;
            r_l_slot_idx   <= slot_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
            r_qne    <= '0;
            r_busy   <= '0;
            r_next_ok <= '0;
            for (int i = 0; i < SEMS; i++) begin
                r_count[i] <= '0;
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
            end
            for (int i = 0; i < SLOTS; i++) begin
                r_next[i]  <= '0;
                r_owner[i] <= '0;
            end
            r_o_status  <= cse_pkg::ST_OK;
            r_o_id      <= '0;
            r_o_blocked <= 1'b0;
            r_o_wake    <= 1'b0;
            r_o_who     <= '0;
        end else if (i_ctl.commit) begin
            r_o_status  <= cse_pkg::ST_OK;
            r_o_id      <= '0;
            r_o_blocked <= 1'b0;
            r_o_wake    <= 1'b0;
            r_o_who     <= '0;
            if (r_op == cse_pkg::OP_INIT) begin
                if (r_l_sem_found) begin
                    r_in_use[r_l_sem_idx] <= 1'b1;
                    r_count[r_l_sem_idx]  <= CW'(signed'({1'b0, r_init}));
                    r_o_id                <= 5'(r_l_sem_idx);
                end else begin
                    r_o_status <= cse_pkg::ST_NO_SEM;
                end
            end else if (op_ok && (r_op == cse_pkg::OP_WAIT)) begin
                if (!c_dec[CW-1]) begin
                    r_count[sidx] <= c_dec;
                end else if (!r_l_slot_found) begin
                    r_o_status <= cse_pkg::ST_FULL;
                end else begin
                    r_count[sidx]            <= c_dec;
                    r_owner[r_l_slot_idx]    <= r_pid;
                    r_busy[r_l_slot_idx]     <= 1'b1;
                    r_next_ok[r_l_slot_idx]  <= 1'b0;
                    if (!r_l_qne) begin
                        r_head[sidx] <= r_l_slot_idx;
                        r_qne[sidx]  <= 1'b1;
                    end else begin
                        r_next[r_l_tail]    <= r_l_slot_idx;
                        r_next_ok[r_l_tail] <= 1'b1;
                    end
                    r_tail[sidx] <= r_l_slot_idx;
                    r_o_blocked  <= 1'b1;
                end
            end else if (op_ok) begin
                r_count[sidx] <= c_inc;
                if (r_l_qne) begin
                    r_head[sidx]        <= r_l_next_h;
                    r_qne[sidx]         <= r_l_next_ok_h;
                    r_next_ok[r_l_head] <= 1'b0;
                    r_busy[r_l_head]    <= 1'b0;
                    if (!r_l_next_ok_h) begin
                        r_tail[sidx] <= '0;
                    end
                    r_o_wake <= 1'b1;
                    r_o_who  <= r_l_owner_h;
                end
            end
        end
    end

    assign o_status         = r_o_status;
    assign o_allocated_id   = r_o_id;
    assign o_caller_blocked = r_o_blocked;
    assign o_wake_valid     = r_o_wake;
    assign o_wake_process   = 8'(r_o_who);

    a_block_wake_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_o_blocked && r_o_wake))
        else $error("blocked and woken in one result");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_status != cse_pkg::ST_OK) |-> (!r_o_blocked && !r_o_wake && (r_o_id == '0)))
        else $error("error result carries payload");

    a_slot_was_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.commit && op_ok && (r_op == cse_pkg::OP_WAIT) && c_dec[CW-1]
         && r_l_slot_found) |-> !r_busy[r_l_slot_idx])
        else $error("waiter placed in a busy slot");

    a_head_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.commit && op_ok && (r_op == cse_pkg::OP_SIGNAL) && r_l_qne)
        |-> r_busy[r_l_head])
        else $error("queue head slot not busy");

endmodule

`default_nettype wire

### sv/counting_semaphore_fifo_engine_unit.sv
// top level of the semaphore table engine: controller plus datapath
// depends on cse_pkg, cse_ctrl and cse_dp
// Each request is captured, then the semaphore entry, the head waiter and the lowest free
// semaphore and waiter slot are read, then the tables are updated and the result register
// loaded, and then the result is offered until the receiver takes it; o_stall holds off
// new requests meanwhile, and a new request is taken in the cycle after the result
// transaction. All tables are cleared by reset, with no clearing pass.
`default_nettype none

module counting_semaphore_fifo_engine_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [7:0]  i_process_id,
    input  wire logic [4:0]  i_semaphore_id,
    input  wire logic [14:0] i_initial_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [4:0]       o_allocated_id,
    output logic             o_caller_blocked,
    output logic             o_wake_valid,
    output logic [7:0]       o_wake_process
);

    cse_pkg::t_ctl ctl;
    cse_pkg::t_sts sts;

    cse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    cse_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .o_sts            (sts),
        .i_opcode         (i_opcode),
        .i_process_id     (i_process_id),
        .i_semaphore_id   (i_semaphore_id),
        .i_initial_value  (i_initial_value),
        .o_status         (o_status),
        .o_allocated_id   (o_allocated_id),
        .o_caller_blocked (o_caller_blocked),
        .o_wake_valid     (o_wake_valid),
        .o_wake_process   (o_wake_process)
    );

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// self-checking testbench for counting_semaphore_fifo_engine_unit with a semaphore table model
// depends on cse_pkg and the engine rtl; drives the valid/stall channels and checks every reply
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cse_pkg::*;

    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    localparam int NO_SLOT = -1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int RANDOM_REQUESTS = 1100;
    localparam int PILE_UP = 0;
    localparam int DRAIN = 1;
    localparam int MIXED = 2;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] alloc_id;
        logic       blocked;
        logic       wake;
        logic [7:0] wake_pid;
    } t_reply;

    class t_semaphore_tracker;
        bit                      sem_taken[SEM_COUNT];
        logic signed [CNT_W-1:0] level[SEM_COUNT];
        int                      head[SEM_COUNT];
        int                      tail[SEM_COUNT];
        int                      link[SLOT_COUNT];
        int                      owner[SLOT_COUNT];
        t_reply                  pending_replies[$];
        int                      failures;

        function new();
            for (int i = 0; i < SEM_COUNT; i++) begin
                sem_taken[i] = 1'b0;
                level[i] = '0;
                head[i] = NO_SLOT;
                tail[i] = 0;
            end
            for (int i = 0; i < SLOT_COUNT; i++) begin
                link[i] = NO_SLOT;
                owner[i] = NO_SLOT;
            end
            failures = 0;
        endfunction

        function void note_request(logic [1:0] op, logic [7:0] pid, logic [4:0] sid,
                                   logic [14:0] iv);
            t_reply                  r;
            logic signed [CNT_W-1:0] c;
            int                      s;
            int                      who;
            r = '0;
            s = NO_SLOT;
            if (op == OP_INIT) begin
                for (int i = 0; i < SEM_COUNT && s == NO_SLOT; i++)
                    if (!sem_taken[i]) s = i;
                if (s == NO_SLOT) begin
                    r.status = ST_NO_SEM;
                end else begin
                    sem_taken[s] = 1'b1;
                    level[s] = {2'b00, iv};
                    r.alloc_id = s[4:0];
                end
            end else if (op == OP_WAIT && sid < SEM_COUNT) begin
                c = level[sid];
                if (c > CNT_MIN) c = c - 1;
                if (c >= 0) begin
                    level[sid] = c;
                end else begin
                    for (int i = 0; i < SLOT_COUNT && s == NO_SLOT; i++)
                        if (owner[i] == NO_SLOT) s = i;
                    if (s == NO_SLOT) begin
                        r.status = ST_FULL;
                    end else begin
                        level[sid] = c;
                        owner[s] = int'(pid) & ((1 << PID_BITS) - 1);
                        link[s] = NO_SLOT;
                        if (head[sid] == NO_SLOT) head[sid] = s;
                        else link[tail[sid]] = s;
                        tail[sid] = s;
                        r.blocked = 1'b1;
                    end
                end
            end else if (op == OP_SIGNAL && sid < SEM_COUNT) begin
                if (level[sid] < CNT_MAX) level[sid] = level[sid] + 1;
                s = head[sid];
                if (s != NO_SLOT) begin
                    who = owner[s];
                    head[sid] = link[s];
                    link[s] = NO_SLOT;
                    owner[s] = NO_SLOT;
                    if (head[sid] == NO_SLOT) tail[sid] = 0;
                    r.wake = 1'b1;
                    r.wake_pid = who[7:0];
                end
            end
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic [1:0] st, logic [4:0] id, logic blk, logic wv,
                                  logic [7:0] wp);
            t_reply e;
            if (pending_replies.size() == 0) begin
                $error("reply transaction with no request outstanding");
                failures++;
                return;
            end
            e = pending_replies.pop_front();
            if (st !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, st);
                failures++;
            end
            if (id !== e.alloc_id) begin
                $error("allocated_id: expected %0d, got %0d", e.alloc_id, id);
                failures++;
            end
            if (blk !== e.blocked) begin
                $error("caller_blocked: expected %0d, got %0d", e.blocked, blk);
                failures++;
            end
            if (wv !== e.wake) begin
                $error("wake_valid: expected %0d, got %0d", e.wake, wv);
                failures++;
            end
            if (wp !== e.wake_pid) begin
                $error("wake_process: expected %0d, got %0d", e.wake_pid, wp);
                failures++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = '0;
    logic [7:0]  i_process_id = '0;
    logic [4:0]  i_semaphore_id = '0;
    logic [14:0] i_initial_value = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [4:0]  o_allocated_id;
    logic        o_caller_blocked;
    logic        o_wake_valid;
    logic [7:0]  o_wake_process;

    t_semaphore_tracker tracker;
    bit holdoff_req = 1'b0;
    int quiet_cycles = 0;

    counting_semaphore_fifo_engine_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_process_id     (i_process_id),
        .i_semaphore_id   (i_semaphore_id),
        .i_initial_value  (i_initial_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_allocated_id   (o_allocated_id),
        .o_caller_blocked (o_caller_blocked),
        .o_wake_valid     (o_wake_valid),
        .o_wake_process   (o_wake_process)
    );

    always #1 i_clk = ~i_clk;

    task automatic send_request(logic [1:0] op, logic [7:0] pid, logic [4:0] sid,
                                logic [14:0] iv);
        i_valid <= 1'b1;
        i_opcode <= op;
        i_process_id <= pid;
        i_semaphore_id <= sid;
        i_initial_value <= iv;
        do @(posedge i_clk); while (o_stall);
        tracker.note_request(op, pid, sid, iv);
    endtask

    task automatic pause_sender(int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            tracker.check_reply(o_status, o_allocated_id, o_caller_blocked, o_wake_valid,
                                o_wake_process);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver stall pattern, with one long hold-off once random traffic starts
    initial begin
        int  kind;
        int  span;
        bit  holdoff_done;
        holdoff_done = 1'b0;
        forever begin
            if (holdoff_req && !holdoff_done) begin
                holdoff_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            end
            kind = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span) begin
                if (kind == 0) i_stall <= 1'b0;
                else if (kind == 1) i_stall <= ($urandom_range(0, 99) < 25);
                else if (kind == 2) i_stall <= ($urandom_range(0, 99) < 60);
                else i_stall <= ((span % 8) < 3);
                span--;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        int          counted;
        int          mode;
        int          seq_left;
        int          burst_left;
        int          r;
        bit          gapless;
        logic [1:0]  op;
        logic [4:0]  sid;
        logic [14:0] iv;
        tracker = new();
        counted = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(OP_INIT, 8'h00, 5'd31, 15'd0);
        send_request(OP_INIT, 8'hFF, 5'd0, 15'h7FFF);
        send_request(OP_INIT, 8'h12, 5'd7, 15'd1);
        send_request(OP_WAIT, 8'h00, 5'd0, 15'h7FFF);
        send_request(OP_WAIT, 8'hFF, 5'd0, 15'd0);
        send_request(OP_SIGNAL, 8'h11, 5'd0, 15'd0);
        send_request(OP_SIGNAL, 8'h22, 5'd0, 15'd0);
        send_request(OP_SIGNAL, 8'h33, 5'd0, 15'd0);
        send_request(OP_WAIT, 8'h44, 5'd2, 15'd0);
        send_request(OP_WAIT, 8'h5A, 5'd2, 15'd0);
        // wait and signal on semaphores never allocated
        send_request(OP_WAIT, 8'hAA, 5'd31, 15'd0);
        send_request(OP_SIGNAL, 8'h01, 5'd31, 15'd0);
        send_request(OP_SIGNAL, 8'h02, 5'd16, 15'd0);
        send_request(OP_UNKNOWN, 8'h55, 5'd5, 15'h5555);
        send_request(OP_UNKNOWN, 8'hAA, 5'd26, 15'h2AAA);
        send_request(OP_WAIT, 8'h66, 5'd1, 15'd0);
        send_request(OP_SIGNAL, 8'h77, 5'd1, 15'd0);
        send_request(OP_SIGNAL, 8'h88, 5'd2, 15'd0);
        send_request(OP_WAIT, 8'h3C, 5'd1, 15'd0);

        holdoff_req = 1'b1;
        while (counted < RANDOM_REQUESTS) begin
            mode = $urandom_range(PILE_UP, MIXED);
            seq_left = $urandom_range(30, 80);
            gapless = ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(1, 20);
            while (seq_left > 0 && counted < RANDOM_REQUESTS) begin
                r = $urandom_range(0, 99);
                if (mode == PILE_UP)
                    op = (r < 70) ? OP_WAIT : (r < 88) ? OP_SIGNAL : (r < 95) ? OP_INIT
                                                                             : OP_UNKNOWN;
                else if (mode == DRAIN)
                    op = (r < 20) ? OP_WAIT : (r < 90) ? OP_SIGNAL : (r < 96) ? OP_INIT
                                                                             : OP_UNKNOWN;
                else
                    op = (r < 40) ? OP_WAIT : (r < 78) ? OP_SIGNAL : (r < 95) ? OP_INIT
                                                                             : OP_UNKNOWN;
                sid = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 7)) : 5'($urandom);
                r = $urandom_range(0, 9);
                if (r < 5) iv = 15'($urandom_range(0, 3));
                else if (r < 9) iv = 15'($urandom);
                else iv = $urandom_range(0, 1) ? 15'h7FFF : 15'd0;
                send_request(op, 8'($urandom), sid, iv);
                if (op != OP_UNKNOWN) counted++;
                seq_left--;
                burst_left--;
                if (!gapless && burst_left == 0) begin
                    pause_sender($urandom_range(1, 15));
                    burst_left = $urandom_range(1, 20);
                end
            end
        end

        i_valid <= 1'b0;
        while (tracker.pending_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
